### sv/ephr_pkg.sv
// Package for the edge-to-PCM hold resampler: sizes, register indexes,
// reset values and step counts of the serial mapping unit.
// No dependencies.
package ephr_pkg;

    localparam int EVENT_DEPTH = 16;
    localparam int EV_IDX_W    = $clog2(EVENT_DEPTH);
    localparam int EV_CNT_W    = $clog2(EVENT_DEPTH + 1);

    localparam int CYCLE_W = 64;
    localparam int LEVEL_W = 16;
    localparam int CLK_W   = 32;
    localparam int RATE_W  = 18;
    localparam int SAMP_W  = 16;
    localparam int DROP_W  = 32;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;

    localparam logic [CFG_IDX_W-1:0] CFG_CLOCK_HZ = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_OUT_RATE = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_LIM = 2'd2;

    localparam logic [CLK_W-1:0]  CLOCK_HZ_RST  = 32'd3500000;
    localparam logic [RATE_W-1:0] OUT_RATE_RST  = 18'd48000;
    localparam logic [SAMP_W-1:0] FRAME_LIM_RST = 16'd4799;

    localparam logic REQ_EVENT   = 1'b0;
    localparam logic REQ_ADVANCE = 1'b1;

    // One multiplier bit and one quotient bit per cycle.
    localparam int MUL_STEPS = RATE_W;
    localparam int DIV_STEPS = CYCLE_W;
    localparam int STEP_W    = $clog2(DIV_STEPS);

    localparam int S_TDATA_W = LEVEL_W + CYCLE_W;
    localparam int M_TDATA_W = 3 * SAMP_W + DROP_W;

endpackage

### sv/edge_to_pcm_hold_resampler_core.sv
// Edge-to-PCM hold resampler: event queue, serial cycle-to-sample mapping
// unit (shift-add multiply, restoring divide) and run emission sequencer.
// Depends on ephr_pkg.
//
// s_ channel: one transfer per request; s_tuser = req_type (0 = level change,
//   1 = advance), s_tdata = {cycle, level}. A level change is queued (up to
//   EVENT_DEPTH); on a full queue drop it, count it and adopt its level.
//   An advance maps its target cycle to a sample count, (cycle * rate mod 2^64)
//   / clock, and emits one hold run per queued event plus a final run.
// m_ channel: m_tdata = {dropped_total, run_level, run_length, run_offset},
//   m_tlast = last run of the advance, m_tuser = frame clamped.
// cfg_ channel: always ready; cfg_index selects clock, rate or frame limit.
// Sequence: each mapping uses the one shared unit for 18 multiply and 64 divide
//   steps, then the ST_POST and ST_SEL compare states. An advance holds s_tready
//   low until done: it maps its target, then reads each queued event (ST_RD, ST_LOAD),
//   maps it and emits the run ending there; one with no elapsed sample gives no run.
// Reset (aresetn low, synchronous): queue empty, held level, sample count and
//   drop count zero, registers at their defaults.
// Stall: a run waits in the output register while m_tready is low; hold the
//   sequencer at the next emission, which adds those cycles to the advance.
module edge_to_pcm_hold_resampler_core
    import ephr_pkg::*;
(
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [S_TDATA_W-1:0]   s_tdata,   // [15:0] level, [79:16] cycle
    input  logic                   s_tuser,   // [0] req_type
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [M_TDATA_W-1:0]   m_tdata,   // [15:0] run_offset, [31:16] run_length,
                                              // [47:32] run_level, [79:48] dropped_total
    output logic                   m_tlast,
    output logic                   m_tuser,   // [0] frame_clamped
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_IDX_W-1:0]   cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    localparam logic [3:0] ST_IDLE = 4'd0;
    localparam logic [3:0] ST_MUL  = 4'd1;
    localparam logic [3:0] ST_DIV  = 4'd2;
    localparam logic [3:0] ST_POST = 4'd3;
    localparam logic [3:0] ST_SEL  = 4'd4;
    localparam logic [3:0] ST_RD   = 4'd5;
    localparam logic [3:0] ST_LOAD = 4'd6;
    localparam logic [3:0] ST_EMIT = 4'd7;
    localparam logic [3:0] ST_LAST = 4'd8;

    // Configuration
    logic [CLK_W-1:0]   clk_hz_reg;
    logic [RATE_W-1:0]  rate_reg;
    logic [SAMP_W-1:0]  limit_reg;

    // Persistent state
    logic [3:0]          state_reg;
    logic [EV_CNT_W-1:0] count_reg;
    logic [LEVEL_W-1:0]  held_reg;
    logic [LEVEL_W-1:0]  last_q_lvl_reg;   // level of the newest queued event
    logic [CYCLE_W-1:0]  done_reg;
    logic [DROP_W-1:0]   drop_reg;

    // Event queue memory
    logic [CYCLE_W-1:0]  mem_cyc [EVENT_DEPTH];
    logic [LEVEL_W-1:0]  mem_lvl [EVENT_DEPTH];
    logic [EV_IDX_W-1:0] rd_addr_reg;
    logic [CYCLE_W-1:0]  rd_cyc_reg;
    logic [LEVEL_W-1:0]  rd_lvl_reg;

    // Shared mapping unit
    logic [CYCLE_W-1:0]  quo_reg;      // product, then quotient
    logic [CYCLE_W-1:0]  mcand_reg;
    logic [RATE_W-1:0]   mplier_reg;
    logic [CLK_W-1:0]    rem_reg;
    logic [STEP_W-1:0]   step_reg;
    logic                tgt_reg;      // mapping the advance target
    logic [CYCLE_W-1:0]  diff_reg;
    logic                gt_reg;

    // Advance context
    logic [CYCLE_W-1:0]  cyc_reg;
    logic [CYCLE_W-1:0]  now_reg;
    logic [SAMP_W-1:0]   frame_reg;
    logic                clamped_reg;
    logic [SAMP_W-1:0]   run_start_reg;
    logic [LEVEL_W-1:0]  run_lvl_reg;
    logic [SAMP_W-1:0]   idx_reg;
    logic [LEVEL_W-1:0]  ev_lvl_reg;
    logic [EV_CNT_W-1:0] ev_i_reg;

    // Output register
    logic                m_tvalid_reg;
    logic [M_TDATA_W-1:0] m_tdata_reg;
    logic                m_tlast_reg;
    logic                m_tuser_reg;

    // Combinational helpers
    logic [CYCLE_W-1:0]  quo_next;
    logic [CLK_W-1:0]    rem_next;
    logic [CLK_W:0]      rem_shift;
    logic                div_ge;
    logic [CYCLE_W:0]    sub_full;
    logic [SAMP_W-1:0]   bound;
    logic [SAMP_W-1:0]   clamp_next;
    logic [EV_CNT_W-1:0] ev_i_next;
    logic                out_free;
    logic                s_acc;
    logic [LEVEL_W-1:0]  in_level;
    logic [CYCLE_W-1:0]  in_cycle;

    assign in_level  = s_tdata[LEVEL_W-1:0];
    assign in_cycle  = s_tdata[S_TDATA_W-1:LEVEL_W];
    assign s_tready  = (state_reg == ST_IDLE);
    assign s_acc     = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;
    assign out_free  = !m_tvalid_reg || m_tready;
    assign ev_i_next = ev_i_reg + 1'b1;

    // Restoring divide step: one quotient bit per cycle. A zero divisor
    // yields all ones, which is the wanted result.
    always_comb begin
        rem_shift = {rem_reg, quo_reg[CYCLE_W-1]};
        div_ge    = (rem_shift >= {1'b0, clk_hz_reg});
        rem_next  = div_ge ? CLK_W'(rem_shift - {1'b0, clk_hz_reg}) : rem_shift[CLK_W-1:0];
        if (state_reg == ST_MUL) begin
            quo_next = mplier_reg[0] ? quo_reg + mcand_reg : quo_reg;
        end else begin
            quo_next = {quo_reg[CYCLE_W-2:0], div_ge};
        end
    end

    assign sub_full = {1'b0, quo_reg} - {1'b0, done_reg};

    // Clamp the difference to the frame limit (target) or frame length (event).
    always_comb begin
        bound = tgt_reg ? limit_reg : frame_reg;
        if ((diff_reg[CYCLE_W-1:SAMP_W] != '0) || (diff_reg[SAMP_W-1:0] > bound)) begin
            clamp_next = bound;
        end else begin
            clamp_next = diff_reg[SAMP_W-1:0];
        end
    end

    // Queue memory: write on accepted event, registered read.
    always_ff @(posedge aclk) begin
        if (s_acc && s_tuser == REQ_EVENT && count_reg < EV_CNT_W'(EVENT_DEPTH)) begin
            mem_cyc[count_reg[EV_IDX_W-1:0]] <= in_cycle;
            mem_lvl[count_reg[EV_IDX_W-1:0]] <= in_level;
        end
        rd_cyc_reg <= mem_cyc[rd_addr_reg];
        rd_lvl_reg <= mem_lvl[rd_addr_reg];
    end

    // Configuration writes; indexes beyond the list are ignored.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clk_hz_reg <= CLOCK_HZ_RST;
            rate_reg   <= OUT_RATE_RST;
            limit_reg  <= FRAME_LIM_RST;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                CFG_CLOCK_HZ:  clk_hz_reg <= cfg_data[CLK_W-1:0];
                CFG_OUT_RATE:  rate_reg   <= cfg_data[RATE_W-1:0];
                CFG_FRAME_LIM: limit_reg  <= cfg_data[SAMP_W-1:0];
                default: ;
            endcase
        end
    end

    // Sequencer and datapath
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            count_reg    <= '0;
            held_reg     <= '0;
            done_reg     <= '0;
            drop_reg     <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            if (m_tvalid_reg && m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE: begin
                    if (s_acc) begin
                        if (s_tuser == REQ_EVENT) begin
                            if (count_reg < EV_CNT_W'(EVENT_DEPTH)) begin
                                count_reg      <= count_reg + 1'b1;
                                last_q_lvl_reg <= in_level;
                            end else begin
                                // Queue full: drop, count, adopt the level.
                                drop_reg <= drop_reg + 1'b1;
                                held_reg <= in_level;
                            end
                        end else begin
                            cyc_reg    <= in_cycle;
                            mcand_reg  <= in_cycle;
                            mplier_reg <= rate_reg;
                            quo_reg    <= '0;
                            step_reg   <= '0;
                            tgt_reg    <= 1'b1;
                            state_reg  <= ST_MUL;
                        end
                    end
                end
                ST_MUL: begin
                    quo_reg    <= quo_next;
                    mcand_reg  <= {mcand_reg[CYCLE_W-2:0], 1'b0};
                    mplier_reg <= {1'b0, mplier_reg[RATE_W-1:1]};
                    step_reg   <= step_reg + 1'b1;
                    if (step_reg == STEP_W'(MUL_STEPS - 1)) begin
                        step_reg  <= '0;
                        rem_reg   <= '0;
                        state_reg <= ST_DIV;
                    end
                end
                ST_DIV: begin
                    quo_reg  <= quo_next;
                    rem_reg  <= rem_next;
                    step_reg <= step_reg + 1'b1;
                    if (step_reg == STEP_W'(DIV_STEPS - 1)) begin
                        state_reg <= ST_POST;
                    end
                end
                ST_POST: begin
                    diff_reg  <= sub_full[CYCLE_W-1:0];
                    gt_reg    <= !sub_full[CYCLE_W] && (sub_full[CYCLE_W-1:0] != '0);
                    state_reg <= ST_SEL;
                end
                ST_SEL: begin
                    if (tgt_reg) begin
                        if (!gt_reg) begin
                            // No sample elapsed: adopt the newest level, flush.
                            if (count_reg != '0) begin
                                held_reg <= last_q_lvl_reg;
                            end
                            count_reg <= '0;
                            state_reg <= ST_IDLE;
                        end else begin
                            now_reg       <= quo_reg;
                            frame_reg     <= clamp_next;
                            clamped_reg   <= (diff_reg[CYCLE_W-1:SAMP_W] != '0) ||
                                             (diff_reg[SAMP_W-1:0] > limit_reg);
                            run_start_reg <= '0;
                            run_lvl_reg   <= held_reg;
                            ev_i_reg      <= '0;
                            rd_addr_reg   <= '0;
                            state_reg     <= (count_reg == '0) ? ST_LAST : ST_RD;
                        end
                    end else begin
                        idx_reg   <= gt_reg ? clamp_next : '0;
                        state_reg <= ST_EMIT;
                    end
                end
                ST_RD: begin
                    state_reg <= ST_LOAD;
                end
                ST_LOAD: begin
                    // Late events are taken at the advance target.
                    mcand_reg  <= (rd_cyc_reg > cyc_reg) ? cyc_reg : rd_cyc_reg;
                    ev_lvl_reg <= rd_lvl_reg;
                    mplier_reg <= rate_reg;
                    quo_reg    <= '0;
                    step_reg   <= '0;
                    tgt_reg    <= 1'b0;
                    state_reg  <= ST_MUL;
                end
                ST_EMIT: begin
                    if (out_free) begin
                        m_tvalid_reg  <= 1'b1;
                        m_tdata_reg   <= {drop_reg, run_lvl_reg,
                                          (idx_reg > run_start_reg) ? idx_reg - run_start_reg
                                                                    : SAMP_W'(0),
                                          run_start_reg};
                        m_tlast_reg   <= 1'b0;
                        m_tuser_reg   <= clamped_reg;
                        run_start_reg <= idx_reg;
                        run_lvl_reg   <= ev_lvl_reg;
                        ev_i_reg      <= ev_i_next;
                        rd_addr_reg   <= ev_i_next[EV_IDX_W-1:0];
                        state_reg     <= (ev_i_next == count_reg) ? ST_LAST : ST_RD;
                    end
                end
                ST_LAST: begin
                    if (out_free) begin
                        m_tvalid_reg <= 1'b1;
                        m_tdata_reg  <= {drop_reg, run_lvl_reg,
                                         (frame_reg > run_start_reg) ? frame_reg - run_start_reg
                                                                     : SAMP_W'(0),
                                         run_start_reg};
                        m_tlast_reg  <= 1'b1;
                        m_tuser_reg  <= clamped_reg;
                        done_reg     <= now_reg;
                        held_reg     <= run_lvl_reg;
                        count_reg    <= '0;
                        state_reg    <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tlast  = m_tlast_reg;
    assign m_tuser  = m_tuser_reg;

endmodule

### bench/tb_edge_to_pcm_hold_resampler_core.sv
// Self-checking bench for edge_to_pcm_hold_resampler_core: level-change and advance requests
// are checked against a run predictor held in a small scoreboard class.
// Depends on ephr_pkg and the core; reads no files.
`timescale 1ns / 100ps

module tb_edge_to_pcm_hold_resampler_core;
    import ephr_pkg::*;

    localparam int unsigned CYCLE_LIMIT   = 1_000_000;
    localparam int unsigned SETTLE_CYCLES = 2000;   // above the worst advance with a full queue
    localparam int unsigned HOLD_CYCLES   = 400;
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

    // One expected hold run, as it should leave the result channel.
    typedef struct {
        logic [SAMP_W-1:0]         offset;
        logic [SAMP_W-1:0]         length;
        logic signed [LEVEL_W-1:0] level;
        logic                      last;
        logic                      clamped;
        logic [DROP_W-1:0]         dropped;
    } hold_run_t;

    // Predicts the runs of every advance and compares them with what comes out.
    class hold_run_scoreboard;
        logic [CLK_W-1:0]   clock_hz;
        logic [RATE_W-1:0]  out_rate;
        logic [SAMP_W-1:0]  frame_limit;
        logic [CYCLE_W-1:0] ev_cycle [EVENT_DEPTH];
        logic [LEVEL_W-1:0] ev_level [EVENT_DEPTH];
        int unsigned        ev_count;
        logic [LEVEL_W-1:0] held_level;
        logic [CYCLE_W-1:0] samples_done;
        logic [DROP_W-1:0]  drops;
        hold_run_t          pending_runs[$];
        int unsigned        mismatches;
        int unsigned        runs_checked;
        int unsigned        frames_rendered;
        int unsigned        clamped_frames;

        function new();
            clock_hz        = CLOCK_HZ_RST;
            out_rate        = OUT_RATE_RST;
            frame_limit     = FRAME_LIM_RST;
            ev_count        = 0;
            held_level      = '0;
            samples_done    = '0;
            drops           = '0;
            mismatches      = 0;
            runs_checked    = 0;
            frames_rendered = 0;
            clamped_frames  = 0;
        endfunction

        function void write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] v);
            case (idx)
                CFG_CLOCK_HZ:  clock_hz    = v;
                CFG_OUT_RATE:  out_rate    = v[RATE_W-1:0];
                CFG_FRAME_LIM: frame_limit = v[SAMP_W-1:0];
                default: ;
            endcase
        endfunction

        // Cycle to running sample count; the product wraps at 64 bits.
        function logic [CYCLE_W-1:0] to_samples(input logic [CYCLE_W-1:0] cyc);
            logic [CYCLE_W-1:0] prod;
            prod = cyc * CYCLE_W'(out_rate);
            if (clock_hz == '0) return '1;
            return prod / CYCLE_W'(clock_hz);
        endfunction

        function void add_run(input logic [SAMP_W-1:0] off, input logic [SAMP_W-1:0] len,
                              input logic [LEVEL_W-1:0] lvl, input logic last, input logic clamp);
            hold_run_t r;
            r.offset  = off;
            r.length  = len;
            r.level   = lvl;
            r.last    = last;
            r.clamped = clamp;
            r.dropped = drops;
            pending_runs.push_back(r);
        endfunction

        function void note_input(input logic req, input logic [LEVEL_W-1:0] lvl,
                                 input logic [CYCLE_W-1:0] cyc);
            logic [CYCLE_W-1:0] now_cnt, span, ec, et;
            logic [SAMP_W-1:0]  frame, idx, run_start;
            logic [LEVEL_W-1:0] run_lvl;
            logic               clamp;
            int unsigned        i;
            if (req == REQ_EVENT) begin
                if (ev_count >= EVENT_DEPTH) begin
                    drops      = drops + 1'b1;
                    held_level = lvl;
                end else begin
                    ev_cycle[ev_count] = cyc;
                    ev_level[ev_count] = lvl;
                    ev_count++;
                end
                return;
            end
            now_cnt = to_samples(cyc);
            if (now_cnt <= samples_done) begin
                // nothing elapsed: adopt the newest level, flush the queue
                if (ev_count > 0) held_level = ev_level[ev_count-1];
                ev_count = 0;
                return;
            end
            span  = now_cnt - samples_done;
            clamp = span > CYCLE_W'(frame_limit);
            frame = clamp ? frame_limit : span[SAMP_W-1:0];
            run_start = '0;
            run_lvl   = held_level;
            for (i = 0; i < ev_count; i++) begin
                ec = (ev_cycle[i] > cyc) ? cyc : ev_cycle[i];
                et = to_samples(ec);
                if (et > samples_done)
                    idx = (et - samples_done > CYCLE_W'(frame)) ? frame
                                                                : SAMP_W'(et - samples_done);
                else
                    idx = '0;
                add_run(run_start, (idx > run_start) ? idx - run_start : '0, run_lvl, 1'b0,
                        clamp);
                run_start = idx;
                run_lvl   = ev_level[i];
            end
            add_run(run_start, (frame > run_start) ? frame - run_start : '0, run_lvl, 1'b1,
                    clamp);
            samples_done = now_cnt;
            held_level   = run_lvl;
            ev_count     = 0;
            frames_rendered++;
            if (clamp) clamped_frames++;
        endfunction

        task report(input string what);
            if (mismatches < 100) $display("mismatch at %0t: %s", $time, what);
            mismatches++;
        endtask

        task check_result(input logic [M_TDATA_W-1:0] data, input logic last,
                          input logic clamped);
            hold_run_t exp_run;
            if (pending_runs.size() == 0) begin
                report($sformatf("run at offset %0d with none pending", data[SAMP_W-1:0]));
                return;
            end
            exp_run = pending_runs.pop_front();
            runs_checked++;
            if (data[SAMP_W-1:0] !== exp_run.offset)
                report($sformatf("run_offset %0d, want %0d", data[SAMP_W-1:0], exp_run.offset));
            if (data[2*SAMP_W-1:SAMP_W] !== exp_run.length)
                report($sformatf("run_length %0d, want %0d", data[2*SAMP_W-1:SAMP_W],
                                 exp_run.length));
            if (data[3*SAMP_W-1:2*SAMP_W] !== exp_run.level)
                report($sformatf("run_level %0d, want %0d",
                                 $signed(data[3*SAMP_W-1:2*SAMP_W]), exp_run.level));
            if (data[M_TDATA_W-1:3*SAMP_W] !== exp_run.dropped)
                report($sformatf("dropped_total %0d, want %0d", data[M_TDATA_W-1:3*SAMP_W],
                                 exp_run.dropped));
            if (last !== exp_run.last)
                report($sformatf("last_run %b, want %b", last, exp_run.last));
            if (clamped !== exp_run.clamped)
                report($sformatf("frame_clamped %b, want %b", clamped, exp_run.clamped));
        endtask
    endclass

    logic                  aclk = 1'b0;
    logic                  aresetn;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [S_TDATA_W-1:0]  s_tdata;    // [15:0] level, [79:16] cycle
    logic                  s_tuser;    // [0] req_type
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [M_TDATA_W-1:0]  m_tdata;    // [15:0] offset, [31:16] length, [47:32] level,
                                       // [79:48] dropped_total
    logic                  m_tlast;
    logic                  m_tuser;    // [0] frame_clamped
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    hold_run_scoreboard sb;
    bit          tx_idles = 1'b1;
    bit          rx_idles = 1'b1;
    int unsigned hold_requests = 0;
    int unsigned hold_seen = 0;
    int unsigned stall_left = 0;
    int unsigned cycle_count = 0;
    int unsigned items_sent = 0;
    int unsigned settings_applied = 0;

    edge_to_pcm_hold_resampler_core i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #2 aclk = ~aclk;

    // Receiver: random backpressure, or a long hold-off when the stimulus asks for one.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else if (hold_requests != hold_seen) begin
            hold_seen  <= hold_requests;
            stall_left <= HOLD_CYCLES;
            m_tready   <= 1'b0;
        end else if (stall_left != 0) begin
            stall_left <= stall_left - 1;
            m_tready   <= 1'b0;
        end else begin
            m_tready <= rx_idles ? ($urandom_range(99) >= 25) : 1'b1;
        end
    end

    // Check every run transfer against the oldest predicted run.
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) sb.check_result(m_tdata, m_tlast, m_tuser);
    end

    // Watchdog: a stuck handshake ends the run as a failure.
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("tb_edge_to_pcm_hold_resampler_core: done, errors");
            $finish;
        end
    end

    function automatic logic [CYCLE_W-1:0] rand64();
        return {$urandom, $urandom};
    endfunction

    // Smallest (round_up) or largest cycle whose mapping reaches the given sample count;
    // counts stay small, so the 64-bit product never wraps here.
    function automatic logic [CYCLE_W-1:0] cycle_for(input logic [CYCLE_W-1:0] count,
                                                     input bit round_up);
        logic [127:0] num;
        if (sb.out_rate == '0) return rand64();
        num = 128'(count) * 128'(sb.clock_hz);
        if (round_up) num = num + 128'(sb.out_rate) - 128'd1;
        return CYCLE_W'(num / 128'(sb.out_rate));
    endfunction

    // Offer one request and hold it until the transfer; idle now and then before it.
    task automatic send_request(input logic req, input logic [LEVEL_W-1:0] lvl,
                                input logic [CYCLE_W-1:0] cyc);
        if (tx_idles && $urandom_range(99) < 25) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(4, 1)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= req;
        s_tdata  <= {cyc, lvl};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        sb.note_input(req, lvl, cyc);
        items_sent++;
    endtask

    // Drop valid and wait until every predicted run has been seen.
    task automatic drain_results();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (sb.pending_runs.size() != 0) @(posedge aclk);
    endtask

    // Drain, then give an advance that yields nothing time to finish its mapping.
    task automatic settle();
        drain_results();
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                  input logic [CFG_DATA_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        sb.write_reg(idx, value);
    endtask

    // Write all three registers back to back while the core is idle.
    task automatic apply_setting(input logic [CFG_DATA_W-1:0] clk_v,
                                 input logic [CFG_DATA_W-1:0] rate_v,
                                 input logic [CFG_DATA_W-1:0] frame_v, input bit poke_unused);
        settle();
        if (poke_unused) write_register(CFG_UNUSED, $urandom);
        write_register(CFG_CLOCK_HZ, clk_v);
        write_register(CFG_OUT_RATE, rate_v);
        write_register(CFG_FRAME_LIM, frame_v);
        cfg_valid <= 1'b0;
        @(posedge aclk);
        settings_applied++;
    endtask

    // One frame: ev_num level changes placed around the next advance, then the advance.
    // Most events fall inside the frame; some land late, before the frame, or anywhere.
    task automatic send_frame(input int unsigned ev_num);
        logic [CYCLE_W-1:0] first_cyc, adv_cyc, span, step, ec, elapsed;
        logic [LEVEL_W-1:0] lvl;
        int unsigned        fl, roll, k;
        bit                 ordered;
        fl   = (sb.frame_limit == '0) ? 1 : sb.frame_limit;
        roll = $urandom_range(99);
        if (roll < 10) elapsed = '0;
        else if (roll < 85) elapsed = CYCLE_W'($urandom_range(fl, 1));
        else elapsed = CYCLE_W'(fl + $urandom_range(3000, 1));
        first_cyc = cycle_for(sb.samples_done, 1'b1);
        adv_cyc   = (elapsed == '0) ? cycle_for(sb.samples_done, 1'b0)
                                    : cycle_for(sb.samples_done + elapsed, 1'b1);
        span      = (adv_cyc > first_cyc) ? adv_cyc - first_cyc : '0;
        step      = span / CYCLE_W'(ev_num + 1);
        ordered   = ($urandom_range(99) < 70);
        for (k = 0; k < ev_num; k++) begin
            roll = $urandom_range(99);
            if (roll < 5) ec = rand64();
            else if (roll < 12) ec = adv_cyc + CYCLE_W'($urandom_range(5000) + 1);
            else if (roll < 20) ec = (first_cyc == '0) ? '0 : rand64() % first_cyc;
            else if (ordered)
                ec = first_cyc + step * CYCLE_W'(k) + ((step != '0) ? rand64() % step : '0);
            else ec = first_cyc + rand64() % (span + 1);
            roll = $urandom_range(99);
            if (roll < 10) lvl = 16'h8000;
            else if (roll < 20) lvl = 16'h7FFF;
            else lvl = LEVEL_W'($urandom);
            send_request(REQ_EVENT, lvl, ec);
        end
        send_request(REQ_ADVANCE, LEVEL_W'($urandom), adv_cyc);
    endtask

    task automatic run_random_frames(input int unsigned budget);
        int unsigned stop_at, roll, n;
        stop_at = items_sent + budget;
        while (items_sent < stop_at) begin
            roll = $urandom_range(99);
            if (roll < 10) n = $urandom_range(20, 17);     // overflow the queue
            else if (roll < 20) n = 0;
            else n = $urandom_range(16, 1);
            send_frame(n);
            // now and then pause until every run is back
            if ($urandom_range(5) == 0) drain_results();
        end
    endtask

    initial begin
        int unsigned k, n;
        sb = new();
        aresetn   <= 1'b0;
        s_tvalid  <= 1'b0;
        s_tdata   <= '0;
        s_tuser   <= REQ_EVENT;
        cfg_valid <= 1'b0;
        cfg_index <= CFG_CLOCK_HZ;
        cfg_data  <= '0;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed part, reset registers (3.5 MHz clock, 48 kHz output).
        // Advance to cycle zero with nothing queued: nothing elapsed, no run.
        send_request(REQ_ADVANCE, 16'h0000, '0);
        // Second event lands before the first (zero-length run), third is past the target.
        send_request(REQ_EVENT, 16'h8000, cycle_for(64'd100, 1'b1));
        send_request(REQ_EVENT, 16'h7FFF, cycle_for(64'd50, 1'b1));
        send_request(REQ_EVENT, 16'h1234, '1);
        send_request(REQ_ADVANCE, 16'hFFFF, cycle_for(64'd200, 1'b1));
        // Fill the queue: first event before the frame, the tail beyond the frame limit,
        // one more dropped; the advance overshoots the frame limit and gets clamped.
        send_request(REQ_EVENT, 16'h00FF, '0);
        for (k = 1; k < EVENT_DEPTH; k++)
            send_request(REQ_EVENT, LEVEL_W'(k * 16'h0911),
                         cycle_for(64'd200 + 64'(k * 350), 1'b1));
        send_request(REQ_EVENT, 16'h7FFF, cycle_for(64'd300, 1'b1));
        send_request(REQ_ADVANCE, 16'h5A5A, cycle_for(64'd6200, 1'b1));
        // Queued event, then an advance that maps to no new sample: level adopted only.
        send_request(REQ_EVENT, 16'h0101, cycle_for(64'd6300, 1'b1));
        send_request(REQ_ADVANCE, 16'h0000, cycle_for(sb.samples_done, 1'b0));

        run_random_frames(24);

        // One sample per cycle, one-sample frames: an advance that spans more than one sample clamps.
        apply_setting(32'd1, 32'd1, 32'd1, 1'b0);
        hold_requests <= hold_requests + 1;
        run_random_frames(24);

        // Largest clock, widest frame; no idling on either side.
        apply_setting(32'hFFFF_FFFF, 32'd192000, 32'd65535, 1'b0);
        tx_idles = 1'b0;
        rx_idles <= 1'b0;
        run_random_frames(24);
        tx_idles = 1'b1;
        rx_idles <= 1'b1;

        // Upper data bits are cut off: rate all ones, frame limit zero.
        apply_setting($urandom_range(32'hFFFF_FFFF, 1), 32'hFFFF_FFFF, 32'hFFFF_0000, 1'b0);
        hold_requests <= hold_requests + 1;
        run_random_frames(24);

        apply_setting($urandom_range(50_000_000, 1), $urandom_range(192000, 8000),
                      $urandom_range(2000, 16), 1'b1);
        run_random_frames(24);

        apply_setting(32'd3_500_000, 32'd44100, $urandom_range(65535, 1), 1'b0);
        run_random_frames(24);

        // Rate zero maps everything to sample zero: queues only flush.
        apply_setting($urandom_range(32'hFFFF_FFFF, 1), 32'd0, 32'd100, 1'b0);
        repeat (3) begin
            n = $urandom_range(3, 1);
            repeat (n) send_request(REQ_EVENT, LEVEL_W'($urandom), rand64());
            send_request(REQ_ADVANCE, LEVEL_W'($urandom), rand64());
        end

        // Advance to the last cycle, then a zero divisor, which maps every cycle to the top
        // sample count; they close the run.
        apply_setting(CLOCK_HZ_RST, OUT_RATE_RST, FRAME_LIM_RST, 1'b0);
        send_request(REQ_EVENT, LEVEL_W'($urandom), rand64());
        send_request(REQ_EVENT, LEVEL_W'($urandom), rand64());
        send_request(REQ_ADVANCE, LEVEL_W'($urandom), '1);
        apply_setting(32'd0, OUT_RATE_RST, FRAME_LIM_RST, 1'b0);
        send_request(REQ_EVENT, LEVEL_W'($urandom), rand64());
        send_request(REQ_ADVANCE, LEVEL_W'($urandom), rand64());
        send_request(REQ_EVENT, LEVEL_W'($urandom), rand64());
        send_request(REQ_ADVANCE, LEVEL_W'($urandom), rand64());

        settle();
        $display("summary: %0d requests, %0d runs checked in %0d frames (%0d clamped), %0d drops",
                 items_sent, sb.runs_checked, sb.frames_rendered, sb.clamped_frames, sb.drops);
        $display("summary: %0d register settings incl. zero divisor, zero rate, zero frame limit",
                 settings_applied);
        if (sb.mismatches == 0) begin
            $display("tb_edge_to_pcm_hold_resampler_core: done, clean");
        end else begin
            $display("tb_edge_to_pcm_hold_resampler_core: done, errors");
        end
        $finish;
    end

endmodule

### sim.f
sv/ephr_pkg.sv
sv/edge_to_pcm_hold_resampler_core.sv
bench/tb_edge_to_pcm_hold_resampler_core.sv
